// ===== rtl/vtv_pkg.sv =====
// Package for the vertex transform and viewport stage.
// Holds the word types, codes, constants and saturation helper; no dependencies.
`timescale 1ns / 1ps

package vtv_pkg;

    // Item codes
    typedef enum logic [1:0]
    {
        OP_LOAD_POS = 2'd0,
        OP_LOAD_NRM = 2'd1,
        OP_XFORM    = 2'd2
    } op_t;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 14;
    localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_TOP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VIEWPORT_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_ENABLE   = 3'd4;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // Quotient bits of the divide by w: 32 bit magnitude shifted up by 16
    localparam int DIV_STEPS = 48;

    // Q16.16 constants
    localparam logic signed [32:0] Q_ONE_33   = 33'sd65536;
    localparam logic signed [65:0] ROUND_HALF = 66'sd32768;
    localparam logic signed [65:0] SAT_MAX    = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN    = -66'sd2147483648;

    // Identity matrix, row major
    localparam logic [31:0] IDENTITY [16] = '{
        32'h0001_0000, 32'h0, 32'h0, 32'h0,
        32'h0, 32'h0001_0000, 32'h0, 32'h0,
        32'h0, 32'h0, 32'h0001_0000, 32'h0,
        32'h0, 32'h0, 32'h0, 32'h0001_0000
    };

    typedef struct packed
    {
        op_t                opcode;
        logic [3:0]         element_index;
        logic signed [31:0] coefficient;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] pos_w;
        logic signed [31:0] norm_x;
        logic signed [31:0] norm_y;
        logic signed [31:0] norm_z;
    } in_t;

    typedef struct packed
    {
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic signed [31:0] depth;
        logic signed [31:0] clip_w;
        logic signed [31:0] out_norm_x;
        logic signed [31:0] out_norm_y;
        logic signed [31:0] out_norm_z;
    } out_t;

    typedef struct packed
    {
        logic signed [13:0] viewport_left;
        logic signed [13:0] viewport_top;
        logic [13:0]        viewport_width;
        logic [13:0]        viewport_height;
        logic               normal_enable;
    } cfg_t;

    // Word handed from front to back: clip coordinates and final normal
    typedef struct packed
    {
        logic signed [31:0] clip_x;
        logic signed [31:0] clip_y;
        logic signed [31:0] clip_z;
        logic signed [31:0] clip_w;
        logic signed [31:0] nrm_x;
        logic signed [31:0] nrm_y;
        logic signed [31:0] nrm_z;
    } xform_t;

    // Clamp a wide signed value to the signed 32 bit range
    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [31:0] r;
        if (x > SAT_MAX)
            r = 32'sh7fff_ffff;
        else if (x < SAT_MIN)
            r = 32'sh8000_0000;
        else
            r = x[31:0];
        return r;
    endfunction

endpackage

// ===== rtl/vtv_front.sv =====
// Front of the vertex transform: takes items, applies matrix loads, and runs
// the matrix products with rounding and saturation. Depends on vtv_pkg.
`timescale 1ns / 1ps

module vtv_front
    import vtv_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   vtx_valid,
    output logic   vtx_stall,
    input  in_t    vtx,
    input  logic   normal_enable,
    input  logic   q_full,
    output logic   push,
    output xform_t push_word
);

    logic f_en;
    logic accept;

    logic [31:0] pos_m_reg [16];
    logic [31:0] nrm_m_reg [16];

    logic               s1_valid_reg;
    logic               s1_ld_valid_reg;
    in_t                s1_reg;
    logic signed [31:0] vec [4];

    logic               s2_valid_reg;
    logic signed [63:0] pos_p_reg [16];
    logic signed [63:0] nrm_p_reg [9];
    logic signed [31:0] s2_nrm_reg [3];

    logic               s3_valid_reg;
    logic signed [65:0] pos_s_next [4];
    logic signed [65:0] nrm_s_next [3];
    logic signed [65:0] pos_s_reg [4];
    logic signed [65:0] nrm_s_reg [3];
    logic signed [31:0] s3_nrm_reg [3];

    logic signed [31:0] clip [4];
    logic signed [31:0] nrm [3];

    // Whole front advances together while the queue has room
    assign f_en      = !q_full;
    assign vtx_stall = q_full;
    assign accept    = vtx_valid && f_en;

    // Apply matrix loads from the first stage, at the same edge that the
    // products read the matrices, so a transform ahead of a load sees the old value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                pos_m_reg[i] <= IDENTITY[i];
                nrm_m_reg[i] <= IDENTITY[i];
            end
        end
        else if (f_en && s1_ld_valid_reg)
        begin
            unique case (s1_reg.opcode)
                OP_LOAD_POS: pos_m_reg[s1_reg.element_index] <= s1_reg.coefficient;
                OP_LOAD_NRM: nrm_m_reg[s1_reg.element_index] <= s1_reg.coefficient;
                default: ;
            endcase
        end
    end

    // Valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s1_ld_valid_reg <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
        end
        else if (f_en)
        begin
            s1_valid_reg    <= accept && (vtx.opcode == OP_XFORM);
            s1_ld_valid_reg <= accept && ((vtx.opcode == OP_LOAD_POS) ||
                                          (vtx.opcode == OP_LOAD_NRM));
            s2_valid_reg    <= s1_valid_reg;
            s3_valid_reg    <= s2_valid_reg;
        end
    end

    assign vec[0] = s1_reg.pos_x;
    assign vec[1] = s1_reg.pos_y;
    assign vec[2] = s1_reg.pos_z;
    assign vec[3] = s1_reg.pos_w;

    // Hold the vertex, then form the products against the current matrices
    always_ff @(posedge clk)
    begin
        if (f_en)
        begin
            s1_reg <= vtx;
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    pos_p_reg[r * 4 + c] <= $signed(pos_m_reg[r * 4 + c]) * vec[c];
                end
            end
            for (int r = 0; r < 3; r++)
            begin
                nrm_p_reg[r * 3 + 0] <= $signed(nrm_m_reg[r * 4 + 0]) * s1_reg.norm_x;
                nrm_p_reg[r * 3 + 1] <= $signed(nrm_m_reg[r * 4 + 1]) * s1_reg.norm_y;
                nrm_p_reg[r * 3 + 2] <= $signed(nrm_m_reg[r * 4 + 2]) * s1_reg.norm_z;
            end
            s2_nrm_reg[0] <= s1_reg.norm_x;
            s2_nrm_reg[1] <= s1_reg.norm_y;
            s2_nrm_reg[2] <= s1_reg.norm_z;
            pos_s_reg     <= pos_s_next;
            nrm_s_reg     <= nrm_s_next;
            s3_nrm_reg    <= s2_nrm_reg;
        end
    end

    // Sum each row exactly and add the rounding half
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            pos_s_next[r] = 66'(pos_p_reg[r * 4 + 0]) + 66'(pos_p_reg[r * 4 + 1])
                          + 66'(pos_p_reg[r * 4 + 2]) + 66'(pos_p_reg[r * 4 + 3])
                          + ROUND_HALF;
        end
        for (int r = 0; r < 3; r++)
        begin
            nrm_s_next[r] = 66'(nrm_p_reg[r * 3 + 0]) + 66'(nrm_p_reg[r * 3 + 1])
                          + 66'(nrm_p_reg[r * 3 + 2]) + ROUND_HALF;
        end
    end

    // Drop the fraction, clamp, and pick the normal source
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            clip[r] = sat32(pos_s_reg[r] >>> 16);
        end
        for (int r = 0; r < 3; r++)
        begin
            nrm[r] = normal_enable ? sat32(nrm_s_reg[r] >>> 16) : s3_nrm_reg[r];
        end
    end

    assign push             = f_en && s3_valid_reg;
    assign push_word.clip_x = clip[0];
    assign push_word.clip_y = clip[1];
    assign push_word.clip_z = clip[2];
    assign push_word.clip_w = clip[3];
    assign push_word.nrm_x  = nrm[0];
    assign push_word.nrm_y  = nrm[1];
    assign push_word.nrm_z  = nrm[2];

endmodule

// ===== rtl/vtv_queue.sv =====
// Short queue of transformed words between front and back.
// Depends on vtv_pkg for the word type.
`timescale 1ns / 1ps

module vtv_queue
    import vtv_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  xform_t push_word,
    output logic   full,
    input  logic   pop,
    output xform_t head,
    output logic   empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    xform_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_pop;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign head   = mem_reg[rd_ptr_reg];
    assign do_pop = pop && !empty;

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (!push && do_pop)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Store the word
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_word;
    end

endmodule

// ===== rtl/vtv_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, three lanes that
// share one divisor, with a side word carried alongside. Depends on vtv_pkg.
`timescale 1ns / 1ps

module vtv_div
    import vtv_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [DIV_STEPS-1:0]  dividend [3],
    input  logic [31:0]           divisor,
    input  logic [SIDE_W-1:0]     side_in,
    output logic                  out_valid,
    output logic [DIV_STEPS-1:0]  quotient [3],
    output logic [SIDE_W-1:0]     side_out
);

    logic                 valid_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] aq_reg    [DIV_STEPS][3];
    logic [31:0]          rem_reg   [DIV_STEPS][3];
    logic [31:0]          d_reg     [DIV_STEPS];
    logic [SIDE_W-1:0]    side_reg  [DIV_STEPS];

    logic                 src_valid [DIV_STEPS];
    logic [DIV_STEPS-1:0] src_aq    [DIV_STEPS][3];
    logic [31:0]          src_rem   [DIV_STEPS][3];
    logic [31:0]          src_d     [DIV_STEPS];
    logic [SIDE_W-1:0]    src_side  [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_stage
        logic [32:0] trial [3];
        logic        fits  [3];

        // Feed each stage from the ports or the stage before
        if (k == 0)
        begin : g_first
            assign src_valid[k] = in_valid;
            assign src_d[k]     = divisor;
            assign src_side[k]  = side_in;
            for (genvar l = 0; l < 3; l++)
            begin : g_lane
                assign src_aq[k][l]  = dividend[l];
                assign src_rem[k][l] = '0;
            end
        end
        else
        begin : g_next
            assign src_valid[k] = valid_reg[k-1];
            assign src_d[k]     = d_reg[k-1];
            assign src_side[k]  = side_reg[k-1];
            for (genvar l = 0; l < 3; l++)
            begin : g_lane
                assign src_aq[k][l]  = aq_reg[k-1][l];
                assign src_rem[k][l] = rem_reg[k-1][l];
            end
        end

        // Shift in the next dividend bit and try to subtract
        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                trial[l] = {src_rem[k][l], src_aq[k][l][DIV_STEPS-1]};
                fits[l]  = (trial[l] >= {1'b0, src_d[k]});
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= src_valid[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                d_reg[k]    <= src_d[k];
                side_reg[k] <= src_side[k];
                for (int l = 0; l < 3; l++)
                begin
                    aq_reg[k][l]  <= {src_aq[k][l][DIV_STEPS-2:0], fits[l]};
                    rem_reg[k][l] <= fits[l] ? 32'(trial[l] - {1'b0, src_d[k]})
                                             : trial[l][31:0];
                end
            end
        end
    end

    assign out_valid = valid_reg[DIV_STEPS-1];
    assign side_out  = side_reg[DIV_STEPS-1];
    for (genvar l = 0; l < 3; l++)
    begin : g_out
        assign quotient[l] = aq_reg[DIV_STEPS-1][l];
    end

endmodule

// ===== rtl/vtv_back.sv =====
// Back of the vertex transform: divide by w, viewport mapping and the output
// register. Depends on vtv_pkg and vtv_div.
`timescale 1ns / 1ps

module vtv_back
    import vtv_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   head_valid,
    input  xform_t head,
    output logic   pop,
    output logic   res_valid,
    input  logic   res_stall,
    output out_t   res
);

    typedef struct packed
    {
        logic signed [31:0] clip_w;
        logic signed [31:0] nrm_x;
        logic signed [31:0] nrm_y;
        logic signed [31:0] nrm_z;
        logic [2:0]         neg;
    } side_t;

    logic                 b_en;
    logic                 w_zero;
    logic [31:0]          w_mag;
    logic signed [31:0]   lane_c [3];
    logic [31:0]          c_mag  [3];
    logic [DIV_STEPS-1:0] dividend [3];
    logic [31:0]          divisor;
    side_t                side_in;

    logic                 dv_valid;
    logic [DIV_STEPS-1:0] quotient [3];
    logic [$bits(side_t)-1:0] side_raw;
    side_t                dv_side;

    logic                 f1_valid_reg;
    logic signed [31:0]   ndc_reg [3];
    side_t                f1_side_reg;

    logic                 f2_valid_reg;
    logic signed [47:0]   px_reg;
    logic signed [47:0]   py_reg;
    logic signed [31:0]   f2_depth_reg;
    side_t                f2_side_reg;

    logic                 res_valid_reg;
    out_t                 res_reg;

    // Whole back holds while a result waits at the output
    assign b_en = !(res_valid_reg && res_stall);
    assign pop  = b_en && head_valid;

    // Set up magnitudes; w of zero divides the unshifted value by one
    assign lane_c[0] = head.clip_x;
    assign lane_c[1] = head.clip_y;
    assign lane_c[2] = head.clip_z;
    assign w_zero    = (head.clip_w == '0);
    assign w_mag     = head.clip_w[31] ? (~head.clip_w + 1'b1) : head.clip_w;
    assign divisor   = w_zero ? 32'd1 : w_mag;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            c_mag[l]       = lane_c[l][31] ? (~lane_c[l] + 1'b1) : lane_c[l];
            dividend[l]    = w_zero ? {16'b0, c_mag[l]} : {c_mag[l], 16'b0};
            side_in.neg[l] = lane_c[l][31] ^ (head.clip_w[31] && !w_zero);
        end
        side_in.clip_w = head.clip_w;
        side_in.nrm_x  = head.nrm_x;
        side_in.nrm_y  = head.nrm_y;
        side_in.nrm_z  = head.nrm_z;
    end

    vtv_div #(
        .SIDE_W ($bits(side_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (b_en),
        .in_valid  (pop),
        .dividend  (dividend),
        .divisor   (divisor),
        .side_in   (side_in),
        .out_valid (dv_valid),
        .quotient  (quotient),
        .side_out  (side_raw)
    );

    assign dv_side = side_t'(side_raw);

    // Apply the sign and clamp the quotient to 32 bits
    function automatic logic signed [31:0] signed_sat(input logic [DIV_STEPS-1:0] q,
                                                      input logic neg);
        logic signed [31:0] r;
        if (!neg)
            r = (q > DIV_STEPS'(32'h7fff_ffff)) ? 32'sh7fff_ffff : q[31:0];
        else
            r = (q > DIV_STEPS'(33'h0_8000_0000)) ? 32'sh8000_0000 : -q[31:0];
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg  <= 1'b0;
            f2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (b_en)
        begin
            f1_valid_reg  <= dv_valid;
            f2_valid_reg  <= f1_valid_reg;
            res_valid_reg <= f2_valid_reg;
        end
    end

    // Finish the divide, scale into the viewport, then offset and clamp
    always_ff @(posedge clk)
    begin
        if (b_en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                ndc_reg[l] <= signed_sat(quotient[l], dv_side.neg[l]);
            end
            f1_side_reg <= dv_side;

            px_reg <= (33'(ndc_reg[0]) + Q_ONE_33) * $signed({1'b0, cfg.viewport_width});
            py_reg <= (Q_ONE_33 - 33'(ndc_reg[1])) * $signed({1'b0, cfg.viewport_height});
            f2_depth_reg <= ndc_reg[2];
            f2_side_reg  <= f1_side_reg;

            res_reg.screen_x   <= sat32((66'(cfg.viewport_left) <<< 16) + 66'(px_reg >>> 1));
            res_reg.screen_y   <= sat32((66'(cfg.viewport_top) <<< 16) + 66'(py_reg >>> 1));
            res_reg.depth      <= f2_depth_reg;
            res_reg.clip_w     <= f2_side_reg.clip_w;
            res_reg.out_norm_x <= f2_side_reg.nrm_x;
            res_reg.out_norm_y <= f2_side_reg.nrm_y;
            res_reg.out_norm_z <= f2_side_reg.nrm_z;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== rtl/vertex_transform_viewport.sv =====
// Top level of the vertex transform and viewport stage: configuration
// registers, front, queue and back. Depends on vtv_pkg and the vtv_* modules.
//
//   channel  direction  handshake              word
//   vtx      in         vtx_valid / vtx_stall  in_t: load or transform item
//   res      out        res_valid / res_stall  out_t: one per transform item
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item enters per cycle while vtx_stall is low. A transform result passes, after
// its item, through three front stages, the queue, 48 divider stages (one quotient bit
// each) and three mapping stages. Loads take effect for the next item.
// Reset restores identity matrices; clears config, valid bits and queue pointers.
// A held result stalls the back; a full queue stalls the front and raises vtx_stall.
`timescale 1ns / 1ps

module vertex_transform_viewport
    import vtv_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  vtx_valid,
    output logic                  vtx_stall,
    input  in_t                   vtx,
    output logic                  res_valid,
    input  logic                  res_stall,
    output out_t                  res,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t   cfg_reg;
    logic   q_push;
    xform_t q_push_word;
    logic   q_full;
    logic   q_pop;
    xform_t q_head;
    logic   q_empty;

    assign cfg_ready = 1'b1;

    // Write configuration; drop unknown indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_VIEWPORT_LEFT:   cfg_reg.viewport_left   <= cfg_data;
                REG_VIEWPORT_TOP:    cfg_reg.viewport_top    <= cfg_data;
                REG_VIEWPORT_WIDTH:  cfg_reg.viewport_width  <= cfg_data;
                REG_VIEWPORT_HEIGHT: cfg_reg.viewport_height <= cfg_data;
                REG_NORMAL_ENABLE:   cfg_reg.normal_enable   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    vtv_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .vtx_valid     (vtx_valid),
        .vtx_stall     (vtx_stall),
        .vtx           (vtx),
        .normal_enable (cfg_reg.normal_enable),
        .q_full        (q_full),
        .push          (q_push),
        .push_word     (q_push_word)
    );

    vtv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (q_push_word),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    vtv_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (!q_empty),
        .head       (q_head),
        .pop        (q_pop),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

endmodule
